FILE: rtl/ddo_pkg.sv
// package for the odometry block: constants and tables
package ddo_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W = $clog2(CORDIC_STEPS + 1);

    localparam logic [47:0] Q48_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] Q48_MIN = 48'h8000_0000_0000;
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    localparam logic [1:0] CFG_LEFT  = 2'd0;
    localparam logic [1:0] CFG_RIGHT = 2'd1;
    localparam logic [1:0] CFG_GAIN  = 2'd2;

    function automatic logic [31:0] arc_at(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0: r = 32'd536870912;
                5'd1: r = 32'd316933406;
                5'd2: r = 32'd167458907;
                5'd3: r = 32'd85004756;
                5'd4: r = 32'd42667331;
                5'd5: r = 32'd21354465;
                5'd6: r = 32'd10679838;
                5'd7: r = 32'd5340245;
                5'd8: r = 32'd2670163;
                5'd9: r = 32'd1335087;
                5'd10: r = 32'd667544;
                5'd11: r = 32'd333772;
                5'd12: r = 32'd166886;
                5'd13: r = 32'd83443;
                5'd14: r = 32'd41722;
                5'd15: r = 32'd20861;
                5'd16: r = 32'd10430;
                5'd17: r = 32'd5215;
                5'd18: r = 32'd2608;
                5'd19: r = 32'd1304;
                5'd20: r = 32'd652;
                5'd21: r = 32'd326;
                5'd22: r = 32'd163;
                5'd23: r = 32'd81;
                5'd24: r = 32'd41;
                5'd25: r = 32'd20;
                5'd26: r = 32'd10;
                5'd27: r = 32'd5;
                5'd28: r = 32'd3;
                5'd29: r = 32'd1;
                5'd30: r = 32'd1;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage

FILE: rtl/ddo_cordic.sv
// iterative rotation-mode cordic, one micro-rotation per cycle
module ddo_cordic
    import ddo_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [31:0]         angle,
    output logic                done,
    output logic signed [33:0]  cos_out,
    output logic signed [33:0]  sin_out
);

    logic signed [33:0] x_reg, x_next, y_reg, y_next;
    logic signed [32:0] z_reg, z_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               busy_reg, busy_next, flip_reg, flip_next;
    logic               done_reg, done_next;
    logic [31:0]        folded;
    logic               flip_in;
    logic signed [33:0] xs, ys;
    logic signed [32:0] arc;

    always_comb
    begin
        flip_in = angle[31] ^ angle[30];
        folded = flip_in ? angle + 32'h8000_0000 : angle;
        xs = x_reg >>> step_reg;
        ys = y_reg >>> step_reg;
        arc = $signed({1'b0, arc_at(5'(step_reg))});
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        flip_next = flip_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next = CORDIC_X0;
            y_next = '0;
            z_next = {folded[31], folded};
            step_next = '0;
            busy_next = 1'b1;
            flip_next = flip_in;
        end
        else if (busy_reg)
        begin
            if (!z_reg[32])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - arc;
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + arc;
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        flip_reg <= flip_next;
    end

    assign done = done_reg;
    assign cos_out = flip_reg ? -x_reg : x_reg;
    assign sin_out = flip_reg ? -y_reg : y_reg;

endmodule

FILE: rtl/differential_drive_odometry.sv
// top level of the differential-drive odometry block
//
// s_axis carries one update request: left and right absolute encoder counts.
// m_axis returns heading, x, y, path length and a saturation flag per update.
// cfg writes the per-wheel scale factors and the heading gain; write only
// while the block is idle.
// one update runs through a single shared 33x33 signed multiplier: wheel
// scaling and heading, then the iterative cordic, then the x/y products
// and an accumulate step. m_axis_tvalid rises once the accumulate step has
// stored the new pose; the next request can be accepted in the cycle after
// the result is taken.
// s_axis_tready is low from acceptance until the result has been handed
// over; a stalled receiver holds the result and the block waits with it.
// reset clears stored counts, heading and accumulators and restores the
// default scale factors (one inch per count, zero heading gain).
module differential_drive_odometry
    import ddo_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // left_count, right_count
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [175:0] m_axis_tdata,   // heading_angle, pos_x, pos_y, path_length
    output logic         m_axis_tuser,   // saturated
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ML    = 4'd1;
    localparam logic [3:0] S_MR    = 4'd2;
    localparam logic [3:0] S_HLO   = 4'd3;
    localparam logic [3:0] S_HHI   = 4'd4;
    localparam logic [3:0] S_CORD  = 4'd5;
    localparam logic [3:0] S_XLO   = 4'd6;
    localparam logic [3:0] S_XHI   = 4'd7;
    localparam logic [3:0] S_YLO   = 4'd8;
    localparam logic [3:0] S_YHI   = 4'd9;
    localparam logic [3:0] S_ACC   = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0]  state_reg, state_next;
    logic [31:0] lscale_reg, rscale_reg, gain_reg;
    logic [31:0] prev_l_reg, prev_r_reg, head_reg;
    logic [31:0] dl_reg, dr_reg;
    logic signed [56:0] lq_reg;
    logic signed [57:0] diff_reg;
    logic signed [56:0] d_reg;
    logic signed [47:0] x_reg, y_reg, dist_reg;
    logic signed [95:0] px_reg, py_reg;
    logic signed [96:0] hp_reg;
    logic        sat_reg;
    logic signed [33:0] cs_reg, sn_reg;

    // shared multiplier: 33x33 signed, registered product
    logic signed [32:0] ma, mb;
    logic signed [65:0] mp_reg;
    logic        c_start, c_done;
    logic signed [33:0] c_cos, c_sin;
    logic [1:0]  phase_reg;

    ddo_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (c_start),
        .angle   (head_reg),
        .done    (c_done),
        .cos_out (c_cos),
        .sin_out (c_sin)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata = {dist_reg, y_reg, x_reg, head_reg};
    assign m_axis_tuser = sat_reg;
    assign c_start = (state_reg == S_CORD) && (phase_reg == 2'd0);

    // operand select for each multiply step; phase 0 issues, phase 1 uses the product
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (state_reg)
            S_ML: begin ma = $signed({dl_reg[31], dl_reg}); mb = $signed({1'b0, lscale_reg}); end
            S_MR: begin ma = $signed({dr_reg[31], dr_reg}); mb = $signed({1'b0, rscale_reg}); end
            S_HLO: begin ma = $signed({1'b0, diff_reg[31:0]}); mb = $signed({1'b0, gain_reg}); end
            S_HHI: begin ma = $signed({17'd0, diff_reg[47:32]}); mb = $signed({1'b0, gain_reg}); end
            S_XLO: begin ma = $signed({1'b0, d_reg[31:0]}); mb = cs_reg[32:0]; end
            S_XHI: begin ma = $signed({{8{d_reg[56]}}, d_reg[56:32]}); mb = cs_reg[32:0]; end
            S_YLO: begin ma = $signed({1'b0, d_reg[31:0]}); mb = sn_reg[32:0]; end
            S_YHI: begin ma = $signed({{8{d_reg[56]}}, d_reg[56:32]}); mb = sn_reg[32:0]; end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    function automatic logic [48:0] sat_add(input logic signed [47:0] a,
                                            input logic signed [63:0] b);
        logic signed [64:0] s;
        begin
            s = 65'(a) + 65'(b);
            if (s > $signed(65'(Q48_MAX)))
                return {1'b1, Q48_MAX};
            else if (s < $signed({{17{1'b1}}, Q48_MIN}))
                return {1'b1, Q48_MIN};
            else
                return {1'b0, s[47:0]};
        end
    endfunction

    logic [48:0] ax, ay, ad;
    logic signed [63:0] dxw, dyw;
    always_comb
    begin
        // floor(p/2^30); |d| < 2^57 and |c| <= 2^30, result fits 64 bits
        dxw = 64'(px_reg >>> 30);
        dyw = 64'(py_reg >>> 30);
        ax = sat_add(x_reg, dxw);
        ay = sat_add(y_reg, dyw);
        ad = sat_add(dist_reg, 64'(d_reg));
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_axis_tvalid) state_next = S_ML;
            S_ML, S_MR, S_HLO, S_XLO, S_XHI, S_YLO, S_YHI:
                if (phase_reg == 2'd1) state_next = state_reg + 4'd1;
            S_HHI: if (phase_reg == 2'd1) state_next = S_CORD;
            S_CORD: if (c_done) state_next = S_XLO;
            S_ACC: state_next = S_OUT;
            S_OUT: if (m_axis_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= '0;
            lscale_reg <= 32'd16777216;
            rscale_reg <= 32'd16777216;
            gain_reg <= '0;
            prev_l_reg <= '0;
            prev_r_reg <= '0;
            head_reg <= '0;
            x_reg <= '0;
            y_reg <= '0;
            dist_reg <= '0;
            sat_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_next != state_reg)
                phase_reg <= '0;
            else if (phase_reg != 2'd1)
                phase_reg <= phase_reg + 2'd1;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_LEFT: lscale_reg <= cfg_data;
                    CFG_RIGHT: rscale_reg <= cfg_data;
                    CFG_GAIN: gain_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == S_IDLE && s_axis_tvalid)
            begin
                prev_l_reg <= s_axis_tdata[31:0];
                prev_r_reg <= s_axis_tdata[63:32];
            end
            if (state_reg == S_HHI && phase_reg == 2'd1)
                head_reg <= head_reg + hp_reg[47:16] + {mp_reg[15:0], 16'h0000};
            if (state_reg == S_ACC)
            begin
                x_reg <= ax[47:0];
                y_reg <= ay[47:0];
                dist_reg <= ad[47:0];
                sat_reg <= ax[48] | ay[48] | ad[48];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mp_reg <= ma * mb;
        if (state_reg == S_IDLE)
        begin
            dl_reg <= s_axis_tdata[31:0] - prev_l_reg;
            dr_reg <= s_axis_tdata[63:32] - prev_r_reg;
        end
        if (phase_reg == 2'd1)
        begin
            case (state_reg)
                S_ML: lq_reg <= 57'(mp_reg >>> 8);
                S_MR:
                begin
                    diff_reg <= 58'(lq_reg) - 58'(57'(mp_reg >>> 8));
                    d_reg <= 57'((58'(lq_reg) + 58'(57'(mp_reg >>> 8))) >>> 1);
                end
                S_HLO: hp_reg <= 97'(mp_reg);
                S_XLO: px_reg <= 96'(mp_reg);
                S_XHI: px_reg <= px_reg + (96'(mp_reg) <<< 32);
                S_YLO: py_reg <= 96'(mp_reg);
                S_YHI: py_reg <= py_reg + (96'(mp_reg) <<< 32);
                default: ;
            endcase
        end
        if (c_done)
        begin
            cs_reg <= c_cos;
            sn_reg <= c_sin;
        end
    end

endmodule

FILE: sim/differential_drive_odometry_tb.sv
// testbench for the odometry block: directed and random wheel updates checked against a predictor
module differential_drive_odometry_tb;
    import ddo_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] heading;
        logic [47:0] px;
        logic [47:0] py;
        logic [47:0] path;
        logic        sat;
    } pose_t;

    localparam logic [31:0] CORDIC_START = 32'd652032874;
    localparam longint LIMIT = 2000000;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [175:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;

    logic [31:0] left_scale, right_scale, gain;
    logic [31:0] last_left, last_right, heading_q;
    logic signed [47:0] x_q, y_q, dist_q;

    pose_t  pose_q[$];
    int     errors;
    longint cycles;
    bit     long_stalls;

    differential_drive_odometry u_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout");
            $display("FAIL differential_drive_odometry");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic signed [127:0] fshr(logic signed [127:0] v, int s);
        return v >>> s;
    endfunction

    function automatic logic signed [47:0] clip48(logic signed [127:0] v, ref bit flag);
        if (v > 128'sh7FFF_FFFF_FFFF)
        begin
            flag = 1;
            return 48'sh7FFF_FFFF_FFFF;
        end
        if (v < -128'sh8000_0000_0000)
        begin
            flag = 1;
            return -48'sh8000_0000_0000;
        end
        return v[47:0];
    endfunction

    function automatic pose_t predict_pose(logic [31:0] lc, logic [31:0] rc);
        logic signed [127:0] dl, dr, lq, rq, diff, d, cx, cy, z, xs, ys, prod;
        logic [127:0] hp;
        logic [31:0] a;
        bit flip, sat;
        pose_t p;
        dl = $signed(lc - last_left);
        dr = $signed(rc - last_right);
        last_left = lc;
        last_right = rc;
        lq = fshr(dl * $signed({96'd0, left_scale}), 8);
        rq = fshr(dr * $signed({96'd0, right_scale}), 8);
        diff = lq - rq;
        hp = diff * {96'd0, gain};
        heading_q = heading_q + hp[47:16];
        d = fshr(lq + rq, 1);
        flip = (heading_q + 32'h4000_0000) >> 31;
        a = flip ? heading_q + 32'h8000_0000 : heading_q;
        z = $signed(a);
        cx = CORDIC_START;
        cy = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = fshr(cx, i);
            ys = fshr(cy, i);
            if (z >= 0)
            begin
                cx = cx - ys; cy = cy + xs; z = z - arc_at(i[4:0]);
            end
            else
            begin
                cx = cx + ys; cy = cy - xs; z = z + arc_at(i[4:0]);
            end
        end
        if (flip)
        begin
            cx = -cx;
            cy = -cy;
        end
        sat = 0;
        prod = fshr(d * cx, 30);
        x_q = clip48(x_q + prod, sat);
        prod = fshr(d * cy, 30);
        y_q = clip48(y_q + prod, sat);
        dist_q = clip48(dist_q + d, sat);
        p.heading = heading_q;
        p.px = x_q;
        p.py = y_q;
        p.path = dist_q;
        p.sat = sat;
        return p;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch %s: got %h expected %h", what, got, want);
    endtask

    always @(posedge clk)
    begin
        pose_t w;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pose_q.size() == 0)
                    report_mismatch("unexpected result", m_axis_tdata[63:0], 0);
                else
                begin
                    w = pose_q.pop_front();
                    if (m_axis_tdata[31:0] !== w.heading)
                        report_mismatch("heading", m_axis_tdata[31:0], w.heading);
                    if (m_axis_tdata[79:32] !== w.px)
                        report_mismatch("pos_x", m_axis_tdata[79:32], w.px);
                    if (m_axis_tdata[127:80] !== w.py)
                        report_mismatch("pos_y", m_axis_tdata[127:80], w.py);
                    if (m_axis_tdata[175:128] !== w.path)
                        report_mismatch("path_length", m_axis_tdata[175:128], w.path);
                    if (m_axis_tuser !== w.sat)
                        report_mismatch("saturated", m_axis_tuser, w.sat);
                end
            end
            if (long_stalls && $urandom_range(0, 9) == 0)
                m_axis_tready <= 1'b0;
            else
                m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic send_update(logic [31:0] lc, logic [31:0] rc);
        @(posedge clk);
        repeat (gap_len()) @(posedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {rc, lc};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        pose_q.push_back(predict_pose(lc, rc));
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        while (pose_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_LEFT:  left_scale = val;
            CFG_RIGHT: right_scale = val;
            CFG_GAIN:  gain = val;
            default: ;
        endcase
    endtask

    task automatic set_scales(logic [31:0] l, logic [31:0] r, logic [31:0] g);
        write_reg(CFG_LEFT, l);
        write_reg(CFG_RIGHT, r);
        write_reg(CFG_GAIN, g);
    endtask

    task automatic test_defaults();
        send_update(32'd100, 32'd100);
        send_update(32'd50, 32'd150);
        send_update(32'h7FFF_FFFF, 32'h8000_0000);
        send_update(32'h8000_0000, 32'h7FFF_FFFF);
        send_update(32'hFFFF_FFFF, 32'd0);
        send_update(32'd0, 32'hFFFF_FFFF);
    endtask

    task automatic test_turning();
        set_scales(32'h0100_0000, 32'h0100_0000, 32'h0100_0000);
        for (int i = 0; i < 10; i++)
            send_update(last_left + 32'd300, last_right - 32'd200);
        write_reg(2'd3, 32'hDEAD_BEEF);
        send_update(last_left + 32'd10, last_right + 32'd10);
    endtask

    task automatic test_saturation();
        set_scales(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int i = 0; i < 5; i++)
            send_update(last_left + 32'h7FFF_FFFF, last_right + 32'h7FFF_FFFF);
        for (int i = 0; i < 4; i++)
            send_update(last_left + 32'h8000_0000, last_right + 32'h8000_0000);
    endtask

    task automatic test_random();
        logic [31:0] dl, dr;
        for (int ph = 0; ph < 7; ph++)
        begin
            long_stalls = (ph % 2);
            case (ph)
                0: set_scales(32'h0100_0000, 32'h0100_0000, 32'h0001_0000);
                1: set_scales(32'd0, 32'd0, 32'd0);
                default: set_scales($urandom, $urandom, $urandom);
            endcase
            for (int i = 0; i < 150; i++)
            begin
                case ($urandom_range(0, 3))
                    0: begin dl = $urandom; dr = $urandom; end
                    1: begin dl = $urandom_range(0, 2000) - 1000;
                             dr = $urandom_range(0, 2000) - 1000; end
                    default: begin dl = $urandom_range(0, 200000) - 100000;
                                   dr = dl + $urandom_range(0, 200) - 100; end
                endcase
                send_update(last_left + dl, last_right + dr);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_LEFT;
        cfg_data = '0;
        errors = 0;
        cycles = 0;
        long_stalls = 0;
        left_scale = 32'h0100_0000;
        right_scale = 32'h0100_0000;
        gain = 0;
        last_left = 0;
        last_right = 0;
        heading_q = 0;
        x_q = 0;
        y_q = 0;
        dist_q = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_turning();
        test_saturation();
        test_random();
        while (pose_q.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("PASS differential_drive_odometry");
        else
            $display("FAIL differential_drive_odometry");
        $finish;
    end

endmodule
